// ----- rtl/eftf_pkg.sv -----
// Shared constants and codes for the edge-function triangle filler.
`default_nettype none

package eftf_pkg;

    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 64;
    localparam int COORD_BITS_DEF  = 11;

    localparam int WORD_W     = 16;
    localparam int COLS_W     = 8;
    localparam int ROWS_W     = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd25;

    // register index, taken from paddr[2]
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic ACT_FILL = 1'b0;
    localparam logic ACT_READ = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/eftf_if.sv -----
// Valid/ready channel interfaces for fill/read items and their results.
`default_nettype none

interface eftf_in_if
    import eftf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic [WORD_W-1:0]            fill_word;
    logic signed [COORD_BITS-1:0] read_column;
    logic signed [COORD_BITS-1:0] read_row;

    modport source (
        output valid, action, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, fill_word, read_column, read_row,
        input  ready
    );
    modport sink (
        input  valid, action, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, fill_word, read_column, read_row,
        output ready
    );
endinterface

interface eftf_out_if
    import eftf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] read_word;
    logic              read_on_screen;

    modport source (output valid, read_word, read_on_screen, input ready);
    modport sink (input valid, read_word, read_on_screen, output ready);
endinterface

`default_nettype wire

// ----- rtl/eftf_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module eftf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/edge_function_triangle_filler_top.sv -----
// Fill: setup, then one candidate cell of the clipped box per cycle; an empty box skips to done.
// Read: from accept the item passes the multiply, RAM read, data register and output register.
// Off-screen read skips RAM. The next item is taken the cycle after the result register loads.
// The result register lets the next item be accepted while a result waits.
// After reset the frame RAM is cleared, one word per cycle, all MAX_COLUMNS*MAX_ROWS
// words, before the first item is accepted; config writes are taken throughout.
`default_nettype none

module edge_function_triangle_filler_top
    import eftf_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    eftf_in_if.sink                    i_in,
    eftf_out_if.source                 o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int C     = COORD_BITS_DEF;
    localparam int CEW   = $clog2(MAX_COLUMNS + 1);
    localparam int REW   = $clog2(MAX_ROWS + 1);
    localparam int CB    = (CEW > REW) ? CEW : REW;
    localparam int SW    = ((C > CB) ? C : CB) + 2;
    localparam int PW    = 2 * SW;
    localparam int EW    = PW + 1;
    localparam int XB    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int YB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_WALK  = 8'b0000_1000,
        S_RMUL  = 8'b0001_0000,
        S_RADDR = 8'b0010_0000,
        S_RDATA = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef logic signed [SW-1:0] t_sw;
    typedef logic signed [C:0]    t_delta;
    typedef logic signed [EW-1:0] t_edge;

    t_state r_state, n_state;

    // configuration
    logic [COLS_W-1:0] r_cols;
    logic [ROWS_W-1:0] r_rows;
    logic [CEW-1:0]    w_cols_eff;
    logic [REW-1:0]    w_rows_eff;
    t_sw               w_cols_s, w_rows_s;

    // item decode
    logic                 w_in_acc;
    logic signed [C-1:0]  w_vx [3];
    logic signed [C-1:0]  w_vy [3];
    t_sw                  w_vxs [3];
    t_sw                  w_vys [3];
    t_sw                  w_minx, w_maxx, w_miny, w_maxy;
    t_sw                  w_x0, w_x1, w_y0, w_y1;
    t_sw                  w_rx, w_ry;
    logic                 w_empty, w_on_screen;
    t_delta               w_dx [3];
    t_delta               w_dy [3];

    // per-item state
    logic signed [C-1:0] r_ux [3];
    logic signed [C-1:0] r_uy [3];
    t_delta              r_dx [3];
    t_delta              r_dy [3];
    t_edge               r_e  [3];
    t_edge               r_ec [3];
    logic [WORD_W-1:0]   r_word;
    logic [XB-1:0]       r_x0, r_x1, r_x;
    logic [YB-1:0]       r_y0, r_y1, r_y;
    logic [2:0]          r_step;
    logic [AW-1:0]       r_addr_col, r_addr, r_clr_addr;
    logic [WORD_W-1:0]   r_res_word;
    logic                r_res_on;

    // shared multiplier
    t_sw                  w_ma, w_mb, w_x0s, w_y0s;
    logic [1:0]           w_e;
    logic signed [PW-1:0] r_prod;

    // frame RAM port
    logic              w_we;
    logic [AW-1:0]     w_addr;
    logic [WORD_W-1:0] w_wdata, w_rdata;
    logic              w_inside;

    // result register
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_on;
    logic              w_out_load;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[APB_ADDR_W-1])
                REG_COLUMNS: r_cols <= pwdata[COLS_W-1:0];
                REG_ROWS:    r_rows <= pwdata[ROWS_W-1:0];
                default:     r_cols <= r_cols;
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_ADDR_W-1])
            REG_COLUMNS: prdata = APB_DATA_W'(r_cols);
            REG_ROWS:    prdata = APB_DATA_W'(r_rows);
            default:     prdata = '0;
        endcase
    end

    assign w_cols_eff = (32'(r_cols) > 32'(MAX_COLUMNS)) ? CEW'(MAX_COLUMNS) : CEW'(r_cols);
    assign w_rows_eff = (32'(r_rows) > 32'(MAX_ROWS)) ? REW'(MAX_ROWS) : REW'(r_rows);
    assign w_cols_s   = SW'(signed'({1'b0, w_cols_eff}));
    assign w_rows_s   = SW'(signed'({1'b0, w_rows_eff}));

    // ---------------- item decode ----------------
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;

    assign w_vx[0] = i_in.vertex_a_x;
    assign w_vy[0] = i_in.vertex_a_y;
    assign w_vx[1] = i_in.vertex_b_x;
    assign w_vy[1] = i_in.vertex_b_y;
    assign w_vx[2] = i_in.vertex_c_x;
    assign w_vy[2] = i_in.vertex_c_y;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_vxs[i] = SW'(w_vx[i]);
            w_vys[i] = SW'(w_vy[i]);
        end
    end

    // edge e runs from vertex e to vertex e+1 (mod 3)
    assign w_dx[0] = t_delta'(w_vx[1]) - t_delta'(w_vx[0]);
    assign w_dy[0] = t_delta'(w_vy[1]) - t_delta'(w_vy[0]);
    assign w_dx[1] = t_delta'(w_vx[2]) - t_delta'(w_vx[1]);
    assign w_dy[1] = t_delta'(w_vy[2]) - t_delta'(w_vy[1]);
    assign w_dx[2] = t_delta'(w_vx[0]) - t_delta'(w_vx[2]);
    assign w_dy[2] = t_delta'(w_vy[0]) - t_delta'(w_vy[2]);

    always_comb begin
        w_minx = (w_vxs[0] < w_vxs[1]) ? w_vxs[0] : w_vxs[1];
        w_minx = (w_minx < w_vxs[2]) ? w_minx : w_vxs[2];
        w_maxx = (w_vxs[0] > w_vxs[1]) ? w_vxs[0] : w_vxs[1];
        w_maxx = (w_maxx > w_vxs[2]) ? w_maxx : w_vxs[2];
        w_miny = (w_vys[0] < w_vys[1]) ? w_vys[0] : w_vys[1];
        w_miny = (w_miny < w_vys[2]) ? w_miny : w_vys[2];
        w_maxy = (w_vys[0] > w_vys[1]) ? w_vys[0] : w_vys[1];
        w_maxy = (w_maxy > w_vys[2]) ? w_maxy : w_vys[2];
        // clip the box to the screen
        w_x0 = (w_minx < 0) ? '0 : w_minx;
        w_y0 = (w_miny < 0) ? '0 : w_miny;
        w_x1 = (w_maxx > w_cols_s - 1) ? SW'(w_cols_s - 1) : w_maxx;
        w_y1 = (w_maxy > w_rows_s - 1) ? SW'(w_rows_s - 1) : w_maxy;
        w_empty = (w_x0 > w_x1) || (w_y0 > w_y1);
    end

    assign w_rx        = SW'(i_in.read_column);
    assign w_ry        = SW'(i_in.read_row);
    assign w_on_screen = (w_rx >= 0) && (w_ry >= 0) && (w_rx < w_cols_s) && (w_ry < w_rows_s);

    // ---------------- shared multiplier ----------------
    assign w_x0s = SW'(signed'({1'b0, r_x0}));
    assign w_y0s = SW'(signed'({1'b0, r_y0}));
    assign w_e   = r_step[2:1];

    // setup: steps 0..5 form the edge values at the box corner, step 6 rows*x0
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_RMUL) begin
            w_ma = w_rows_s;
            w_mb = SW'(signed'({1'b0, r_x}));
        end else if (r_step == 3'd6) begin
            w_ma = w_rows_s;
            w_mb = w_x0s;
        end else if (r_step < 3'd6) begin
            if (!r_step[0]) begin
                w_ma = w_x0s - SW'(r_ux[w_e]);
                w_mb = SW'(r_dy[w_e]);
            end else begin
                w_ma = w_y0s - SW'(r_uy[w_e]);
                w_mb = SW'(r_dx[w_e]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_ma) * PW'(w_mb);
    end

    // ---------------- frame RAM ----------------
    assign w_inside = !r_ec[0][EW-1] && !r_ec[1][EW-1] && !r_ec[2][EW-1];

    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_addr;
        w_wdata = r_word;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_addr  = r_clr_addr;
                w_wdata = '0;
            end
            S_WALK:  w_we   = w_inside;
            S_RADDR: w_addr = AW'(r_prod) + AW'(r_y);
            default: w_we   = 1'b0;
        endcase
    end

    eftf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // ---------------- sequencer ----------------
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.action)
                        ACT_FILL: n_state = w_empty ? S_DONE : S_SETUP;
                        ACT_READ: n_state = w_on_screen ? S_RMUL : S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SETUP: if (r_step == 3'd7) n_state = S_WALK;
            S_WALK:  if (r_x == r_x1 && r_y == r_y1) n_state = S_DONE;
            S_RMUL:  n_state = S_RADDR;
            S_RADDR: n_state = S_RDATA;
            S_RDATA: n_state = S_DONE;
            S_DONE:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_step     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == S_SETUP) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_res_word <= '0;
                    r_res_on   <= 1'b0;
                    r_word     <= i_in.fill_word;
                    r_x0       <= XB'(w_x0);
                    r_x1       <= XB'(w_x1);
                    r_y0       <= YB'(w_y0);
                    r_y1       <= YB'(w_y1);
                    r_x        <= XB'(w_rx);
                    r_y        <= YB'(w_ry);
                    for (int i = 0; i < 3; i++) begin
                        r_ux[i] <= w_vx[i];
                        r_uy[i] <= w_vy[i];
                        r_dx[i] <= w_dx[i];
                        r_dy[i] <= w_dy[i];
                    end
                end
            end
            S_SETUP: begin
                // r_prod holds the product of the previous step
                case (r_step)
                    3'd1: r_e[0] <= t_edge'(r_prod);
                    3'd2: r_e[0] <= r_e[0] - t_edge'(r_prod);
                    3'd3: r_e[1] <= t_edge'(r_prod);
                    3'd4: r_e[1] <= r_e[1] - t_edge'(r_prod);
                    3'd5: r_e[2] <= t_edge'(r_prod);
                    3'd6: r_e[2] <= r_e[2] - t_edge'(r_prod);
                    3'd7: begin
                        // column base is rows*x + y0
                        r_addr_col <= AW'(r_prod) + AW'(r_y0);
                        r_addr     <= AW'(r_prod) + AW'(r_y0);
                        r_x        <= r_x0;
                        r_y        <= r_y0;
                        for (int i = 0; i < 3; i++) begin
                            r_ec[i] <= r_e[i];
                        end
                    end
                    default: r_e[0] <= r_e[0];
                endcase
            end
            S_WALK: begin
                if (r_y == r_y1) begin
                    // next column: edge values step by dy, address by rows
                    r_x        <= r_x + 1'b1;
                    r_y        <= r_y0;
                    r_addr_col <= r_addr_col + AW'(w_rows_eff);
                    r_addr     <= r_addr_col + AW'(w_rows_eff);
                    for (int i = 0; i < 3; i++) begin
                        r_e[i]  <= r_e[i] + t_edge'(r_dy[i]);
                        r_ec[i] <= r_e[i] + t_edge'(r_dy[i]);
                    end
                end else begin
                    r_y    <= r_y + 1'b1;
                    r_addr <= r_addr + 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        r_ec[i] <= r_ec[i] - t_edge'(r_dx[i]);
                    end
                end
            end
            S_RDATA: begin
                r_res_word <= w_rdata;
                r_res_on   <= 1'b1;
            end
            default: r_res_on <= r_res_on;
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_word <= r_res_word;
            r_out_on   <= r_res_on;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.read_word      = r_out_word;
    assign o_out.read_on_screen = r_out_on;

endmodule

`default_nettype wire
